### src/integer_to_radix_ascii_top_assert.svh
// ---------------------------------------------------------------------------
// integer_to_radix_ascii_top_assert.svh - assertion macros
// Shorthand for the implication checks used in the converter top level.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_TOP_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_TOP_ASSERT_SVH

// same-cycle implication, masked while reset is held
`define I2RA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is held
`define I2RA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/i2ra_pkg.sv
// ---------------------------------------------------------------------------
// i2ra_pkg - shared types and constants
// Widths, character codes, job flags and back-end state for the converter.
// ---------------------------------------------------------------------------
package i2ra_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int BASE_W          = 5;
    localparam int DIGIT_W         = 4;
    localparam int CHAR_W          = 7;
    localparam int STEPS_PER_CYCLE = 8;   // quotient bits per divider cycle
    localparam int FIFO_DEPTH      = 2;

    localparam logic [BASE_W-1:0]  BASE_MIN   = 5'd2;
    localparam logic [BASE_W-1:0]  BASE_MAX   = 5'd16;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE = 4'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;
    localparam logic [CHAR_W-1:0]  CH_ZERO    = 7'h30;  // '0'
    localparam logic [CHAR_W-1:0]  CH_A       = 7'h41;  // 'A'
    localparam logic [CHAR_W-1:0]  CH_MINUS   = 7'h2D;  // '-'

    typedef struct packed {
        logic neg;
        logic zero;
    } t_job_flags;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DIGIT_W-1:0]  rem;
    } t_div_rsp;

    typedef struct packed {
        logic emitting;
        logic div_busy;
    } t_back_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } t_back_state;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        if (d > DIGIT_NINE) begin
            return CH_A + CHAR_W'(d - DIGIT_TEN);
        end
        return CH_ZERO + CHAR_W'(d);
    endfunction

endpackage

### src/integer_to_radix_ascii_top.sv
// ---------------------------------------------------------------------------
// integer_to_radix_ascii_top - signed integer to ASCII in base 2 to 16
// Converts one two's complement value to its characters, most significant
// first, with a leading '-' for negative values and tlast on the final one.
// ---------------------------------------------------------------------------
//
//  port group   dir  payload                                   one word is
//  s_axis_*     in   tdata: value[W-1:0], base[W+4:W], zero pad one number
//  m_axis_*     out  tdata: out_char[6:0], zero pad; tlast     one character
//
//  Each digit is one pass of the divider, which retires eight quotient bits
//  per clock and sets the pace.
//  Reset is synchronous, active low, and empties the queue and the engine.
//  The two-entry job queue takes words while the engine works; m_axis_tready
//  low holds the output word and pauses the stack read-out.
//
module integer_to_radix_ascii_top import i2ra_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int IN_TDW  = ((VALUE_WIDTH + BASE_W + 7) / 8) * 8,
    localparam int OUT_TDW = ((CHAR_W + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [IN_TDW-1:0]  s_axis_tdata,  // value, base, zero pad
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OUT_TDW-1:0] m_axis_tdata,  // out_char, zero pad
    output logic               m_axis_tlast
);

`include "integer_to_radix_ascii_top_assert.svh"

    localparam int JW = VALUE_WIDTH + BASE_W + $bits(t_job_flags);

    logic [VALUE_WIDTH-1:0] w_fr_mag, w_job_mag;
    logic [BASE_W-1:0]      w_fr_base, w_job_base;
    t_job_flags             w_fr_flags, w_job_flags;
    logic [JW-1:0]          w_job_in, w_job_out;
    logic                   w_job_valid, w_job_pop;
    logic [CHAR_W-1:0]      w_char;
    t_back_status           w_status;

    // classify at the input: sign, magnitude, clamped base, zero
    i2ra_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_value (s_axis_tdata[VALUE_WIDTH-1:0]),
        .i_base  (s_axis_tdata[VALUE_WIDTH+BASE_W-1:VALUE_WIDTH]),
        .o_mag   (w_fr_mag),
        .o_base  (w_fr_base),
        .o_flags (w_fr_flags)
    );

    assign w_job_in = {w_fr_flags, w_fr_base, w_fr_mag};

    i2ra_fifo #(
        .WIDTH (JW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (w_job_in),
        .o_valid (w_job_valid),
        .i_pop   (w_job_pop),
        .o_data  (w_job_out)
    );

    assign {w_job_flags, w_job_base, w_job_mag} = w_job_out;

    // divide, stack digits, read them back most significant first
    i2ra_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .o_job_pop   (w_job_pop),
        .i_job_mag   (w_job_mag),
        .i_job_base  (w_job_base),
        .i_job_flags (w_job_flags),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_char      (w_char),
        .o_last      (m_axis_tlast),
        .o_status    (w_status)
    );

    assign m_axis_tdata = OUT_TDW'(w_char);

    // divider must be quiet once read-out has begun
    `I2RA_ASSERT_IMP(a_div_idle_in_emit, i_clk, i_rst_n, w_status.emitting, !w_status.div_busy, "divider busy during read-out")
    // a fresh output word only comes from the stack read-out
    `I2RA_ASSERT_IMP(a_out_from_emit, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(w_status.emitting), "output word outside read-out")

endmodule

### src/i2ra_front.sv
// ---------------------------------------------------------------------------
// i2ra_front - input classification
// Splits sign from magnitude, clamps the base and flags a zero value.
// ---------------------------------------------------------------------------
module i2ra_front import i2ra_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [BASE_W-1:0]      i_base,
    output logic [VALUE_WIDTH-1:0] o_mag,
    output logic [BASE_W-1:0]      o_base,
    output t_job_flags             o_flags
);

    logic w_neg;

    assign w_neg = i_value[VALUE_WIDTH-1];

    // most negative value wraps to 2^(W-1), exact as unsigned
    assign o_mag = w_neg ? (VALUE_WIDTH'(~i_value) + VALUE_WIDTH'(1)) : i_value;

    always_comb begin
        if (i_base < BASE_MIN) begin
            o_base = BASE_MIN;
        end else if (i_base > BASE_MAX) begin
            o_base = BASE_MAX;
        end else begin
            o_base = i_base;
        end
    end

    assign o_flags.neg  = w_neg;
    assign o_flags.zero = (i_value == '0);

endmodule

### src/i2ra_fifo.sv
// ---------------------------------------------------------------------------
// i2ra_fifo - short job queue
// Decouples the input side from the conversion engine.
// ---------------------------------------------------------------------------
module i2ra_fifo import i2ra_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push, w_pop;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### src/i2ra_div.sv
// ---------------------------------------------------------------------------
// i2ra_div - iterative small-divisor divider
// Restoring division, STEPS_PER_CYCLE quotient bits per clock.
// ---------------------------------------------------------------------------
module i2ra_div import i2ra_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [BASE_W-1:0]      i_divisor,
    output logic [VALUE_WIDTH-1:0] o_quot,
    output t_div_rsp               o_rsp
);

    localparam int QW   = ((VALUE_WIDTH + STEPS_PER_CYCLE - 1) / STEPS_PER_CYCLE)
                          * STEPS_PER_CYCLE;
    localparam int CYC  = QW / STEPS_PER_CYCLE;
    localparam int CNTW = $clog2(CYC + 1);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(CYC - 1);

    logic                r_busy, r_done;
    logic [CNTW-1:0]     r_cnt;
    logic [QW-1:0]       r_quot, n_quot;
    logic [DIGIT_W-1:0]  r_rem, n_rem;
    logic [BASE_W-1:0]   r_divisor;

    // dividend shifts out at the top, quotient bits shift in at the bottom
    always_comb begin
        logic [QW-1:0]      q;
        logic [DIGIT_W-1:0] rm;
        logic [BASE_W-1:0]  t;
        q  = r_quot;
        rm = r_rem;
        t  = '0;
        for (int k = 0; k < STEPS_PER_CYCLE; k++) begin
            t = {rm, q[QW-1]};
            q = {q[QW-2:0], 1'b0};
            if (t >= r_divisor) begin
                t    = t - r_divisor;
                q[0] = 1'b1;
            end
            rm = t[DIGIT_W-1:0];
        end
        n_quot = q;
        n_rem  = rm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CNTW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= QW'(i_dividend);
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_quot     = r_quot[VALUE_WIDTH-1:0];
    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

### src/i2ra_back.sv
// ---------------------------------------------------------------------------
// i2ra_back - conversion engine
// Produces digits least significant first into a character stack, then
// reads the stack backwards into the output register.
// ---------------------------------------------------------------------------
module i2ra_back import i2ra_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_valid,
    output logic                   o_job_pop,
    input  logic [VALUE_WIDTH-1:0] i_job_mag,
    input  logic [BASE_W-1:0]      i_job_base,
    input  t_job_flags             i_job_flags,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [CHAR_W-1:0]      o_char,
    output logic                   o_last,
    output t_back_status           o_status
);

    localparam int MAXC = VALUE_WIDTH + 1;
    localparam int AW   = $clog2(MAXC);
    localparam int CW   = $clog2(MAXC + 1);

    t_back_state r_state, n_state;

    logic [CHAR_W-1:0]      r_stack [MAXC];
    logic [BASE_W-1:0]      r_base;
    logic                   r_neg;
    logic [CW-1:0]          r_wptr, n_wptr;
    logic [CW-1:0]          r_rd_cnt;
    logic [AW-1:0]          r_rd_addr;
    logic                   r_rd_vld, r_rd_last;
    logic [CHAR_W-1:0]      r_rdata;
    logic                   r_o_valid, r_o_last;
    logic [CHAR_W-1:0]      r_o_char;

    logic                   w_we, w_finish, w_div_start;
    logic [CHAR_W-1:0]      w_wdata;
    logic [AW-1:0]          w_waddr;
    logic [VALUE_WIDTH-1:0] w_div_dividend, w_quot;
    logic [BASE_W-1:0]      w_div_divisor;
    logic                   w_quot_zero;
    logic                   w_rd_fire, w_out_load;
    t_div_rsp               w_div;

    i2ra_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_quot     (w_quot),
        .o_rsp      (w_div)
    );

    assign w_quot_zero = (w_quot == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job_flags.zero ? ST_EMIT : ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div.done && w_quot_zero) begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_rd_cnt == '0 && !r_rd_vld) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_job_pop      = 1'b0;
        w_we           = 1'b0;
        w_wdata        = CH_ZERO;
        w_finish       = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = w_quot;
        w_div_divisor  = r_base;
        w_waddr        = r_wptr[AW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                w_waddr        = '0;
                w_div_dividend = i_job_mag;
                w_div_divisor  = i_job_base;
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    if (i_job_flags.zero) begin
                        w_we     = 1'b1;
                        w_finish = 1'b1;
                    end else begin
                        w_div_start = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (w_div.done) begin
                    w_we        = 1'b1;
                    w_wdata     = digit_to_ascii(w_div.rem);
                    w_div_start = !w_quot_zero;
                    w_finish    = w_quot_zero && !r_neg;
                end
            end
            ST_SIGN: begin
                w_we     = 1'b1;
                w_wdata  = CH_MINUS;
                w_finish = 1'b1;
            end
            ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    assign n_wptr = ((r_state == ST_IDLE) ? CW'(0) : r_wptr) + CW'(w_we);

    // read ahead one character whenever the output slot will take it
    assign w_out_load = r_rd_vld && (!r_o_valid || i_tready);
    assign w_rd_fire  = (r_state == ST_EMIT) && (r_rd_cnt != '0)
                        && (!r_rd_vld || w_out_load);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wptr    <= '0;
            r_rd_cnt  <= '0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wptr   <= n_wptr;
            r_rd_vld <= w_rd_fire || (r_rd_vld && !w_out_load);
            if (w_finish) begin
                r_rd_cnt <= n_wptr;
            end else if (w_rd_fire) begin
                r_rd_cnt <= r_rd_cnt - CW'(1);
            end
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_base <= i_job_base;
            r_neg  <= i_job_flags.neg;
        end
        if (w_finish) begin
            r_rd_addr <= w_waddr;
        end else if (w_rd_fire) begin
            r_rd_addr <= r_rd_addr - AW'(1);
        end
        if (w_rd_fire) begin
            r_rd_last <= (r_rd_cnt == CW'(1));
        end
        if (w_out_load) begin
            r_o_char <= r_rdata;
            r_o_last <= r_rd_last;
        end
    end

    // character stack
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_stack[w_waddr] <= w_wdata;
        end
        if (w_rd_fire) begin
            r_rdata <= r_stack[r_rd_addr];
        end
    end

    assign o_tvalid          = r_o_valid;
    assign o_char            = r_o_char;
    assign o_last            = r_o_last;
    assign o_status.emitting = (r_state == ST_EMIT);
    assign o_status.div_busy = w_div.busy;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - self-checking bench for integer_to_radix_ascii_top
// Feeds signed 32-bit numbers with bases 0 to 31 into the slave stream and
// checks every character word on the master stream against a local model of
// the radix conversion: sign, digit order, letters above nine, tlast.
// ---------------------------------------------------------------------------
module tb;
    import i2ra_pkg::*;

    localparam int VW      = VALUE_WIDTH_DEF;
    localparam int IN_TDW  = ((VW + BASE_W + 7) / 8) * 8;
    localparam int OUT_TDW = ((CHAR_W + 7) / 8) * 8;
    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_COUNT = 138;
    localparam int QUIET_TAIL   = 30;     // last random numbers run without idling
    localparam int LONG_HOLD    = 600;    // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 200;    // one slow number and then some
    localparam int LIMIT_CYCLES = 400000;

    // one expected character word
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_word;

    // -----------------------------------------------------------------------
    // Scoreboard: turns each accepted number into its characters and checks
    // the output words against them in order.
    // -----------------------------------------------------------------------
    class char_scoreboard;
        t_char_word pending_chars[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        task flag_mismatch(input string what);
            errors++;
            $display("[%0t] conversion error: %s", $time, what);
        endtask

        // Magnitude taken as unsigned, so the most negative value converts too.
        function void note_number(input logic [VW-1:0] value, input logic [BASE_W-1:0] base);
            logic [VW-1:0]      mag;
            int unsigned        radix;
            int unsigned        digit;
            logic [CHAR_W-1:0]  rev[$];
            t_char_word         w;
            mag   = value[VW-1] ? (~value + 1'b1) : value;
            radix = base;
            if (radix < BASE_MIN) radix = BASE_MIN;    // base 0 and 1 act as binary
            if (radix > BASE_MAX) radix = BASE_MAX;    // 17 and up act as hex
            if (mag == '0) begin
                rev = {rev, CH_ZERO};
            end else begin
                while (mag != '0) begin
                    digit = mag % radix;
                    mag   = mag / radix;
                    if (digit > 9) rev = {rev, CH_A + CHAR_W'(digit - 10)};
                    else rev = {rev, CH_ZERO + CHAR_W'(digit)};
                end
                if (value[VW-1]) rev = {rev, CH_MINUS};
            end
            // least significant came first; emit in reverse
            for (int k = rev.size() - 1; k >= 0; k--) begin
                w.ch   = rev[k];
                w.last = (k == 0);
                pending_chars = {pending_chars, w};
            end
        endfunction

        task check_char(input logic [CHAR_W-1:0] ch, input logic last);
            t_char_word w;
            if (pending_chars.size() == 0) begin
                flag_mismatch($sformatf("unexpected word char=%h last=%b", ch, last));
            end else begin
                w = pending_chars.pop_front();
                if (ch !== w.ch)
                    flag_mismatch($sformatf("char %h, wanted %h", ch, w.ch));
                if (last !== w.last)
                    flag_mismatch($sformatf("tlast %b, wanted %b on char %h",
                                            last, w.last, w.ch));
            end
        endtask

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_TDW-1:0]  s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_TDW-1:0] m_axis_tdata;
    logic               m_axis_tlast;

    char_scoreboard sb;
    bit             no_idle;          // suppresses idling on both sides
    bit             long_hold_req;    // asks the receiver for one long hold-off

    integer_to_radix_ascii_top #(
        .VALUE_WIDTH (VW)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // value, base, zero pad
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // out_char, zero pad
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("integer_to_radix_ascii_top: mismatch");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Receiver: random stall bursts and one long hold-off on request, so the
    // job queue fills and tready drops on the input side.
    // -----------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                stall_left = LONG_HOLD - 1;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // output monitor: each accepted word goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_char(m_axis_tdata[CHAR_W-1:0], m_axis_tlast);
    end

    // Offers one number and holds it until the block takes it. tvalid is
    // left high; the caller drops it only when a gap follows.
    task send_number(input logic [VW-1:0] value, input logic [BASE_W-1:0] base);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDW'({base, value});
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_number(value, base);
    endtask

    // random gap after a word, or none
    task sender_gap();
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // mix of small magnitudes, extremes and full-range values
    function automatic logic [VW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return VW'($urandom_range(0, 40));
            1: return VW'(0) - VW'($urandom_range(1, 40));
            2: begin
                case ($urandom_range(0, 3))
                    0: return {1'b1, {(VW-1){1'b0}}};
                    1: return {1'b0, {(VW-1){1'b1}}};
                    2: return '1;
                    default: return '0;
                endcase
            end
            3: return VW'($urandom_range(0, 100000));
            default: return VW'($urandom());
        endcase
    endfunction

    // mostly legal bases; now and then one below two or above sixteen
    function automatic logic [BASE_W-1:0] pick_base();
        if ($urandom_range(0, 6) == 0) return BASE_W'($urandom_range(0, 31));
        return BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
    endfunction

    initial begin
        sb = new();
        no_idle       = 1'b0;
        long_hold_req = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero, extremes, all-ones, letters, clamped bases
        send_number(32'd0, 5'd10);                  sender_gap();
        send_number(32'd0, 5'd2);                   sender_gap();
        send_number(32'd0, 5'd16);                  sender_gap();
        send_number(32'h8000_0000, 5'd2);           sender_gap();
        send_number(32'h8000_0000, 5'd10);          sender_gap();
        send_number(32'h8000_0000, 5'd16);          sender_gap();
        send_number(32'h7FFF_FFFF, 5'd2);           sender_gap();
        send_number(32'h7FFF_FFFF, 5'd10);          sender_gap();
        send_number(32'h7FFF_FFFF, 5'd16);          sender_gap();
        send_number(32'hFFFF_FFFF, 5'd2);           sender_gap();
        send_number(32'hFFFF_FFFF, 5'd16);          sender_gap();
        send_number(32'd255, 5'd16);                sender_gap();
        send_number(32'h00AB_CDEF, 5'd16);          sender_gap();
        send_number(-32'sd12345, 5'd10);            sender_gap();
        send_number(32'd10, 5'd11);                 sender_gap();
        send_number(32'd123456789, 5'd7);           sender_gap();
        send_number(-32'sd987654321, 5'd13);        sender_gap();
        send_number(32'd5, 5'd0);                   sender_gap();
        send_number(32'd6, 5'd1);                   sender_gap();
        send_number(32'd100, 5'd17);                sender_gap();
        send_number(-32'sd100, 5'd31);              sender_gap();
        send_number(32'd3, 5'd3);                   sender_gap();

        // random part; one long receiver hold-off early on, quiet tail
        for (int i = 0; i < RANDOM_COUNT; i++) begin
            if (i == 40) long_hold_req = 1'b1;
            if (i == RANDOM_COUNT - QUIET_TAIL) no_idle = 1'b1;
            send_number(pick_value(), pick_base());
            sender_gap();
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("integer_to_radix_ascii_top: match");
        end else begin
            $display("integer_to_radix_ascii_top: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/i2ra_pkg.sv
src/i2ra_front.sv
src/i2ra_fifo.sv
src/i2ra_div.sv
src/i2ra_back.sv
src/integer_to_radix_ascii_top.sv
sim/tb.sv
